FILE: design/assert_macros.svh
// Assertion helpers included by rvrt_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define RVRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define RVRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/rvrt_pkg.sv
package rvrt_pkg;

  localparam int unsigned RVRT_NUM_DIRS = 4;
  localparam int unsigned RVRT_VC_COUNT = 4;

  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned PORT_W    = 3;
  localparam int unsigned CHANNEL_W = 2;
  localparam int unsigned OWNER_W   = 3;

  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RESERVE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FIND    = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_INVAL   = 3'd5;

  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_RESV  = 2'd1,
    SLOT_INVAL = 2'd2
  } slot_st_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_EXEC   = 3'd1,
    ST_SCAN   = 3'd2,
    ST_COMMIT = 3'd3,
    ST_DONE   = 3'd4
  } ctrl_st_e;

  typedef struct packed {
    logic               available;
    logic [OWNER_W-1:0] owner_output;
    logic               error_flag;
  } rsp_t;

endpackage

FILE: design/rvrt_owner_mem.sv
module rvrt_owner_mem import rvrt_pkg::*; #(
  parameter int unsigned DEPTH = 17,
  parameter int unsigned WIDTH = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/rvrt_ctrl.sv
module rvrt_ctrl import rvrt_pkg::*; #(
  parameter int unsigned NUM_DIRS = RVRT_NUM_DIRS,
  parameter int unsigned VC_COUNT = RVRT_VC_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 busy_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [PORT_W-1:0]    in_port_i,
  input  logic [PORT_W-1:0]    out_port_i,
  input  logic [CHANNEL_W-1:0] channel_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output rsp_t                 rsp_o
);

  localparam int unsigned SlotCnt = NUM_DIRS * VC_COUNT + 1;
  localparam int unsigned SlotW   = $clog2(SlotCnt);
  localparam int unsigned ScanW   = $clog2(NUM_DIRS + 2);
  localparam logic [OWNER_W-1:0] OwnerNone = OWNER_W'(NUM_DIRS + 1);

  ctrl_st_e             state_q, state_d;
  slot_st_e             status_q [SlotCnt];
  slot_st_e             status_d [SlotCnt];
  logic [ACTION_W-1:0]  action_q;
  logic [PORT_W-1:0]    in_port_q, out_port_q;
  logic [CHANNEL_W-1:0] channel_q;
  logic [ScanW-1:0]     scan_q, scan_d;
  logic [ScanW-1:0]     cmp_port_q, cmp_port_d;
  logic                 cmp_vld_q, cmp_vld_d;
  rsp_t                 rsp_q, rsp_d;

  logic                 accept;
  logic                 addr_ok, in_ok, scan_hit, scan_last;
  logic [SlotW-1:0]     idx, code, cmp_slot;
  slot_st_e             idx_st, cmp_st;
  logic                 mem_we;
  logic [SlotW-1:0]     mem_raddr;
  logic [SlotW-1:0]     mem_rdata;

  function automatic logic [SlotW-1:0] slot_of(input int unsigned port,
                                                input int unsigned ch);
    if (port == NUM_DIRS) begin
      return SlotW'(NUM_DIRS * VC_COUNT);
    end
    return SlotW'(port * VC_COUNT + ch);
  endfunction

  // Out-of-range slots only appear on bad addresses, which never use the value.
  function automatic slot_st_e st_at(input slot_st_e st [SlotCnt],
                                     input logic [SlotW-1:0] i);
    if (32'(i) < SlotCnt) begin
      return st[i];
    end
    return SLOT_INVAL;
  endfunction

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign busy_o  = (state_q != ST_IDLE);

  assign addr_ok = (32'(out_port_q) == NUM_DIRS) ||
                   ((32'(out_port_q) < NUM_DIRS) && (32'(channel_q) < VC_COUNT));
  assign in_ok   = (32'(in_port_q) <= NUM_DIRS) && (32'(channel_q) < VC_COUNT);
  assign idx     = slot_of(32'(out_port_q), 32'(channel_q));
  assign code    = slot_of(32'(in_port_q), 32'(channel_q));
  assign idx_st  = st_at(status_q, idx);

  // Shared owner compare: one slot per cycle, pipelined behind the memory read.
  assign cmp_slot  = slot_of(32'(cmp_port_q), 32'(channel_q));
  assign cmp_st    = st_at(status_q, cmp_slot);
  assign scan_hit  = cmp_vld_q && (cmp_st == SLOT_RESV) && (mem_rdata == code);
  assign scan_last = cmp_vld_q && (32'(cmp_port_q) == NUM_DIRS);
  assign mem_raddr = slot_of(32'(scan_q), 32'(channel_q));
  assign mem_we    = (state_q == ST_COMMIT);

  rvrt_owner_mem #(
    .DEPTH(SlotCnt),
    .WIDTH(SlotW)
  ) u_owner_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(idx),
    .wdata_i(code),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    scan_d     = scan_q;
    cmp_port_d = cmp_port_q;
    cmp_vld_d  = 1'b0;
    rsp_d      = rsp_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rsp_d.available    = 1'b0;
        rsp_d.owner_output = OwnerNone;
        rsp_d.error_flag   = 1'b0;
        scan_d             = '0;
        state_d            = ST_DONE;
        unique case (action_q)
          ACT_CLEAR: begin
            for (int i = 0; i < SlotCnt; i++) begin
              if (status_q[i] == SLOT_RESV) begin
                status_d[i] = SLOT_FREE;
              end
            end
          end
          ACT_RESERVE: begin
            if (!addr_ok || !in_ok || idx_st != SLOT_FREE) begin
              rsp_d.error_flag = 1'b1;
            end else begin
              state_d = ST_SCAN;
            end
          end
          ACT_RELEASE: begin
            if (!addr_ok || idx_st != SLOT_RESV) begin
              rsp_d.error_flag = 1'b1;
            end else begin
              status_d[idx] = SLOT_FREE;
            end
          end
          ACT_QUERY: begin
            if (!addr_ok) begin
              rsp_d.error_flag = 1'b1;
            end else begin
              rsp_d.available = (idx_st == SLOT_FREE);
            end
          end
          ACT_FIND: begin
            if (!in_ok) begin
              rsp_d.error_flag = 1'b1;
            end else begin
              state_d = ST_SCAN;
            end
          end
          ACT_INVAL: begin
            if (!addr_ok) begin
              rsp_d.error_flag = 1'b1;
            end else begin
              status_d[idx] = SLOT_INVAL;
            end
          end
          default: begin
            rsp_d.error_flag = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        // Issue the next read while comparing the previous one.
        if (32'(scan_q) <= NUM_DIRS) begin
          cmp_vld_d  = 1'b1;
          cmp_port_d = scan_q;
          scan_d     = scan_q + ScanW'(1);
        end
        if (scan_hit) begin
          cmp_vld_d = 1'b0;
          if (action_q == ACT_RESERVE) begin
            status_d[cmp_slot] = SLOT_FREE;
            state_d            = ST_COMMIT;
          end else begin
            rsp_d.owner_output = OWNER_W'(cmp_port_q);
            state_d            = ST_DONE;
          end
        end else if (scan_last) begin
          cmp_vld_d = 1'b0;
          state_d   = (action_q == ACT_RESERVE) ? ST_COMMIT : ST_DONE;
        end
      end
      ST_COMMIT: begin
        status_d[idx] = SLOT_RESV;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_vld_q <= 1'b0;
      for (int i = 0; i < SlotCnt; i++) begin
        status_q[i] <= SLOT_FREE;
      end
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q   <= action_i;
      in_port_q  <= in_port_i;
      out_port_q <= out_port_i;
      channel_q  <= channel_i;
    end
    scan_q     <= scan_d;
    cmp_port_q <= cmp_port_d;
    rsp_q      <= rsp_d;
  end

  assign rsp_valid_o = (state_q == ST_DONE);
  assign rsp_o       = rsp_q;

`include "assert_macros.svh"

  `RVRT_ASSERT(a_commit_slot_free, (state_q == ST_COMMIT) |-> (idx_st == SLOT_FREE), "reserve claims a slot that is not free")
  `RVRT_ASSERT(a_scan_bound, (state_q == ST_SCAN) |-> (32'(scan_q) <= NUM_DIRS + 1), "owner scan ran past the local port")
  `RVRT_ASSERT(a_done_release, (state_q == ST_DONE && rsp_ready_i) |=> (state_q == ST_IDLE), "result taken but sequencer did not return to idle")
  `RVRT_ASSERT_ALWAYS(a_no_cmp_in_idle, (state_q == ST_IDLE) |-> !cmp_vld_q, "compare pending while idle")

endmodule

FILE: design/router_vc_reservation_table_core.sv
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_stall_o | action_i, in_port_i, out_port_i, channel_i
// result  | out       | out_valid_o/out_stall_i | available_o, owner_output_o, error_flag_o
//
// Clear, release, query, invalidate and unknown actions go from execute straight to done.
// Owner search adds a scan, and a valid reserve a scan and then a commit step: the
// owner compare walks the output slots one per cycle behind the owner memory read.
// Reset (rst_ni low, asynchronous) marks every slot free; no clearing pass.
// A result waits in the output register under out_stall_i while the next item
// is taken; the sequencer holds its result only while that register is full and stalled.
module router_vc_reservation_table_core import rvrt_pkg::*; #(
  parameter int unsigned NUM_DIRS = RVRT_NUM_DIRS,
  parameter int unsigned VC_COUNT = RVRT_VC_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [PORT_W-1:0]    in_port_i,
  input  logic [PORT_W-1:0]    out_port_i,
  input  logic [CHANNEL_W-1:0] channel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 available_o,
  output logic [OWNER_W-1:0]   owner_output_o,
  output logic                 error_flag_o
);

  logic busy;
  logic rsp_valid, rsp_ready;
  rsp_t rsp;
  logic out_valid_q, out_valid_d;
  rsp_t out_q;

  rvrt_ctrl #(
    .NUM_DIRS(NUM_DIRS),
    .VC_COUNT(VC_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (busy),
    .action_i   (action_i),
    .in_port_i  (in_port_i),
    .out_port_i (out_port_i),
    .channel_i  (channel_i),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  assign in_stall_o = busy;
  assign rsp_ready  = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign available_o    = out_q.available;
  assign owner_output_o = out_q.owner_output;
  assign error_flag_o   = out_q.error_flag;

endmodule
